/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while in reset.
`define RTPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define RTPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/rtps_pkg.sv */
// Shared types and constants of the region to TLB page split unit.
`default_nettype none

package rtps_pkg;

  localparam int DEF_TLB_SLOTS   = 64;
  localparam int DEF_MAX_ENTRIES = 64;

  // Address values held in 4K units (bits 31:12).
  localparam int ADDR_UW = 20;
  // Page masks held in 4K units (bits 28:12).
  localparam int MASK_UW = 17;
  // Pair sizes held in 4K units (up to 512M).
  localparam int SIZE_UW = 18;
  localparam int SLOT_CW = 7;

  localparam logic [MASK_UW-1:0] MASK_ODD_U  = 17'h0AAAA;
  localparam logic [MASK_UW-1:0] MASK_EVEN_U = 17'h15554;
  localparam logic [MASK_UW-1:0] GROW_MIN_U  = 17'h00006;
  localparam logic [SIZE_UW-1:0] PAIR_MIN_U  = 18'h00002;
  localparam logic [5:0]         LO_FLAGS    = 6'h2E;

  localparam logic [28:0] MAX_PAGE_MASK_RST = 29'h1FFE000;

  localparam logic REG_MAX_PAGE_MASK = 1'b0;
  localparam logic REG_ID_DEALIAS    = 1'b1;

  typedef struct packed {
    logic [MASK_UW-1:0] mpm_u;
    logic               dealias;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/region_to_tlb_page_split_unit.sv */
// Each region, and each new alignment boundary in it, passes the alignment step and the
// boundary step; the pair size is then shrunk by one shared shift-and-compare step per cycle,
// at most 8 steps per alignment boundary, and an entry is issued once the output is free;
// one region at a time, the next item is taken after the last entry.
// Reset: synchronous active-low rst_n returns the sequencer to idle, drops the output
// item and sets max_page_mask to 0x1FFE000 and id_dealias_enable to 1.
`default_nettype none
`include "assert_macros.svh"

module region_to_tlb_page_split_unit
  import rtps_pkg::*;
#(
  parameter int TLB_SLOTS   = DEF_TLB_SLOTS,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_phys_addr,
  input  wire logic [31:0] in_guest_phys_addr,
  input  wire logic [31:0] in_region_length,
  input  wire logic [7:0]  in_guest_id,
  input  wire logic [5:0]  in_start_slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_entry_high,
  output logic [29:0]      out_entry_low_even,
  output logic [29:0]      out_entry_low_odd,
  output logic [28:0]      out_page_mask,
  output logic [5:0]       out_slot,
  output logic             out_last,
  output logic             out_truncated
);

  cfg_t cfg;

  rtps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rtps_core #(
    .TLB_SLOTS   (TLB_SLOTS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_phys_addr       (in_phys_addr),
    .in_guest_phys_addr (in_guest_phys_addr),
    .in_region_length   (in_region_length),
    .in_guest_id        (in_guest_id),
    .in_start_slot      (in_start_slot),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_entry_high     (out_entry_high),
    .out_entry_low_even (out_entry_low_even),
    .out_entry_low_odd  (out_entry_low_odd),
    .out_page_mask      (out_page_mask),
    .out_slot           (out_slot),
    .out_last           (out_last),
    .out_truncated      (out_truncated)
  );

  `RTPS_ASSERT(a_empty_region_idle, (in_valid && in_ready && in_region_length[31:12] == 20'd0) |=> in_ready, "empty region left the sequencer busy")
  `RTPS_ASSERT(a_trunc_is_last, (out_valid && out_truncated) |-> out_last, "truncated item not marked last")
  `RTPS_ASSERT(a_mask_within_cfg, out_valid |-> ((out_page_mask[28:12] & ~cfg.mpm_u) == 17'd0), "page mask exceeds usable mask")
  `RTPS_ASSERT_ALWAYS(a_reset_idle, !$past(rst_n) |-> (in_ready && !out_valid), "not idle after reset")

endmodule

`default_nettype wire

/* hw/rtl/rtps_cfg.sv */
// Configuration registers, APB access and usable page mask derivation.
`default_nettype none

module rtps_cfg
  import rtps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  logic [28:0] max_page_mask_r, max_page_mask_nxt;
  logic        dealias_r, dealias_nxt;
  logic        wr_en;
  logic        run_ok;
  logic [MASK_UW-1:0] mpm_u;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    max_page_mask_nxt = max_page_mask_r;
    dealias_nxt       = dealias_r;
    if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_MAX_PAGE_MASK: max_page_mask_nxt = cfg_pwdata[28:0];
        REG_ID_DEALIAS:    dealias_nxt       = cfg_pwdata[0];
        default:           dealias_nxt       = dealias_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MAX_PAGE_MASK: cfg_prdata = {3'b0, max_page_mask_r};
      REG_ID_DEALIAS:    cfg_prdata = {31'b0, dealias_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // Only the run of full bit pairs from bits 14:13 upward counts.
  always_comb begin
    mpm_u  = '0;
    run_ok = 1'b1;
    for (int k = 0; k < 8; k++) begin
      run_ok = run_ok & max_page_mask_r[13+2*k] & max_page_mask_r[14+2*k];
      if (run_ok) begin
        mpm_u[1+2*k] = 1'b1;
        mpm_u[2+2*k] = 1'b1;
      end
    end
  end

  assign cfg.mpm_u   = mpm_u;
  assign cfg.dealias = dealias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_page_mask_r <= MAX_PAGE_MASK_RST;
      dealias_r       <= 1'b1;
    end else begin
      max_page_mask_r <= max_page_mask_nxt;
      dealias_r       <= dealias_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rtps_core.sv */
// Split sequencer: alignment step, boundary step and shared size shrink unit.
`default_nettype none

module rtps_core
  import rtps_pkg::*;
#(
  parameter int TLB_SLOTS   = DEF_TLB_SLOTS,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_phys_addr,
  input  wire logic [31:0] in_guest_phys_addr,
  input  wire logic [31:0] in_region_length,
  input  wire logic [7:0]  in_guest_id,
  input  wire logic [5:0]  in_start_slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_entry_high,
  output logic [29:0]      out_entry_low_even,
  output logic [29:0]      out_entry_low_odd,
  output logic [28:0]      out_page_mask,
  output logic [5:0]       out_slot,
  output logic             out_last,
  output logic             out_truncated
);

  localparam int N_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALIGN = 2'd1;
  localparam logic [1:0] ST_TGT   = 2'd2;
  localparam logic [1:0] ST_SIZE  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [ADDR_UW-1:0] pa_r, pa_nxt;
  logic [18:0]        gpa_r, gpa_nxt;
  logic [ADDR_UW-1:0] len_r, len_nxt;
  logic [ADDR_UW-1:0] target_r, target_nxt;
  logic [SIZE_UW-1:0] size_r, size_nxt;
  logic [MASK_UW-1:0] bound_r, bound_nxt;
  logic [7:0]         gid_r, gid_nxt;
  logic [SLOT_CW-1:0] slot_r, slot_nxt;
  logic [N_W-1:0]     n_r, n_nxt;

  logic               ov_r, ov_nxt;
  logic [31:0]        o_hi_r, o_hi_nxt;
  logic [29:0]        o_lo0_r, o_lo0_nxt;
  logic [29:0]        o_lo1_r, o_lo1_nxt;
  logic [28:0]        o_pm_r, o_pm_nxt;
  logic [5:0]         o_slot_r, o_slot_nxt;
  logic               o_last_r, o_last_nxt;
  logic               o_trunc_r, o_trunc_nxt;

  logic [ADDR_UW-1:0] low_bit, below;
  logic [MASK_UW-1:0] am_raw, am;
  logic [ADDR_UW-1:0] bound_gap;
  logic [ADDR_UW-1:0] size_w, used, tsub, new_len, new_target, pa_odd;
  logic               shrink, out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !ov_r || out_ready;

  always_comb begin
    low_bit = pa_r & (~pa_r + ADDR_UW'(1));
    below   = low_bit - ADDR_UW'(1);
    am_raw  = (pa_r == '0) ? '0 : (cfg.mpm_u & below[MASK_UW-1:0]);
    am      = am_raw & (((am_raw >> 1) & MASK_ODD_U) | ((am_raw << 1) & MASK_EVEN_U));
    bound_gap = (ADDR_UW'(bound_r) + ADDR_UW'(2)) - ADDR_UW'(pa_r[MASK_UW-1:0] & bound_r);
    size_w  = ADDR_UW'(size_r);
    shrink  = (size_r > PAIR_MIN_U) && (size_w > target_r);
    used    = (size_w < len_r) ? size_w : len_r;
    tsub    = (size_w < target_r) ? size_w : target_r;
    new_len = len_r - used;
    new_target = target_r - tsub;
    pa_odd  = pa_r + ADDR_UW'(size_r[SIZE_UW-1:1]);
  end

  always_comb begin
    state_nxt  = state_r;
    pa_nxt     = pa_r;
    gpa_nxt    = gpa_r;
    len_nxt    = len_r;
    target_nxt = target_r;
    size_nxt   = size_r;
    bound_nxt  = bound_r;
    gid_nxt    = gid_r;
    slot_nxt   = slot_r;
    n_nxt      = n_r;
    ov_nxt     = ov_r && !out_ready;
    o_hi_nxt   = o_hi_r;
    o_lo0_nxt  = o_lo0_r;
    o_lo1_nxt  = o_lo1_r;
    o_pm_nxt   = o_pm_r;
    o_slot_nxt = o_slot_r;
    o_last_nxt = o_last_r;
    o_trunc_nxt = o_trunc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pa_nxt   = in_phys_addr[31:12];
          gpa_nxt  = in_guest_phys_addr[31:13];
          len_nxt  = in_region_length[31:12];
          gid_nxt  = cfg.dealias ? in_guest_id : 8'd0;
          slot_nxt = {1'b0, in_start_slot};
          n_nxt    = '0;
          if (in_region_length[31:12] != '0 && int'(in_start_slot) < TLB_SLOTS) begin
            state_nxt = ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        bound_nxt = (am != '0) ? (((am << 2) | am) & cfg.mpm_u) : GROW_MIN_U;
        state_nxt = ST_TGT;
      end
      ST_TGT: begin
        target_nxt = (bound_gap < len_r) ? bound_gap : len_r;
        size_nxt   = SIZE_UW'(cfg.mpm_u) + PAIR_MIN_U;
        state_nxt  = ST_SIZE;
      end
      ST_SIZE: begin
        if (shrink) begin
          size_nxt = size_r >> 2;
        end else if (out_free) begin
          ov_nxt      = 1'b1;
          o_hi_nxt    = {gpa_r, 5'b0, gid_r};
          o_lo0_nxt   = {4'b0, pa_r, LO_FLAGS};
          o_lo1_nxt   = {4'b0, pa_odd, LO_FLAGS};
          o_pm_nxt    = {MASK_UW'(size_r - PAIR_MIN_U), 12'b0};
          o_slot_nxt  = slot_r[5:0];
          o_last_nxt  = 1'b0;
          o_trunc_nxt = 1'b0;
          len_nxt     = new_len;
          target_nxt  = new_target;
          pa_nxt      = pa_r + size_w;
          gpa_nxt     = gpa_r + 19'(size_r[SIZE_UW-1:1]);
          slot_nxt    = slot_r + SLOT_CW'(1);
          n_nxt       = n_r + N_W'(1);
          if (new_len == '0) begin
            o_last_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else if (int'(n_r) + 1 >= MAX_ENTRIES || int'(slot_r) + 1 >= TLB_SLOTS) begin
            o_last_nxt  = 1'b1;
            o_trunc_nxt = 1'b1;
            state_nxt   = ST_IDLE;
          end else if (new_target == '0) begin
            state_nxt = ST_ALIGN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r      <= pa_nxt;
    gpa_r     <= gpa_nxt;
    len_r     <= len_nxt;
    target_r  <= target_nxt;
    size_r    <= size_nxt;
    bound_r   <= bound_nxt;
    gid_r     <= gid_nxt;
    slot_r    <= slot_nxt;
    n_r       <= n_nxt;
    o_hi_r    <= o_hi_nxt;
    o_lo0_r   <= o_lo0_nxt;
    o_lo1_r   <= o_lo1_nxt;
    o_pm_r    <= o_pm_nxt;
    o_slot_r  <= o_slot_nxt;
    o_last_r  <= o_last_nxt;
    o_trunc_r <= o_trunc_nxt;
  end

  assign out_valid          = ov_r;
  assign out_entry_high     = o_hi_r;
  assign out_entry_low_even = o_lo0_r;
  assign out_entry_low_odd  = o_lo1_r;
  assign out_page_mask      = o_pm_r;
  assign out_slot           = o_slot_r;
  assign out_last           = o_last_r;
  assign out_truncated      = o_trunc_r;

endmodule

`default_nettype wire
